// ===== design/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// shared types and constants for the sync trigger clock generator
// ----------------------------------------------------------------------------
package stc_pkg;

    // register and field widths
    localparam int CHAN_CFG_W = 38;
    localparam int SRC_CFG_W  = 10;
    localparam int ELAPSED_W  = 32;
    localparam int MS_W       = 16;
    localparam int FORM_W     = 3;
    localparam int ID_W       = 3;

    localparam logic [CHAN_CFG_W-1:0] CHAN_CFG_RESET = 38'h00_0040_0000;

    // channel register layout
    localparam int CFG_ACTIVE_BIT = 0;
    localparam int CFG_DELAY_LSB  = 1;
    localparam int CFG_FORM_LSB   = 17;
    localparam int CFG_PULSE_LSB  = 20;
    localparam int CFG_STOP_BIT   = 36;
    localparam int CFG_CLK_BIT    = 37;

    // source register layout
    localparam int SRC_START_LSB = 0;
    localparam int SRC_STOP_LSB  = 3;
    localparam int SRC_EVENT_LSB = 6;
    localparam int SRC_EVEN_BIT  = 9;

    // channel output forms
    localparam logic [FORM_W-1:0] FORM_FALL_TRIG = 3'd0;
    localparam logic [FORM_W-1:0] FORM_RISE_TRIG = 3'd1;
    localparam logic [FORM_W-1:0] FORM_FALL_EDGE = 3'd2;
    localparam logic [FORM_W-1:0] FORM_RISE_EDGE = 3'd3;
    localparam logic [FORM_W-1:0] FORM_ANY_EDGE  = 3'd4;
    localparam logic [FORM_W-1:0] FORM_FALL_CLK  = 3'd5;
    localparam logic [FORM_W-1:0] FORM_RISE_CLK  = 3'd6;
    localparam logic [FORM_W-1:0] FORM_SEQUENCE  = 3'd7;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_CLOCK = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;

    typedef enum logic [2:0] {
        MSG_NONE    = 3'd0,
        MSG_STARTED = 3'd1,
        MSG_STOPPED = 3'd2,
        MSG_EVENT   = 3'd3,
        MSG_UNUSED  = 3'd4
    } t_msg;

    // per-beat control broadcast to every channel lane
    typedef struct packed {
        logic                 tick;     // tick with the ms counter live
        logic                 running;  // run flag before this beat
        logic                 clock;    // clock timer expiry
        logic [ID_W-1:0]      clock_ch; // channel of the expiry
        logic                 start;    // run starts on this beat
        logic                 stop;     // run stops on this beat
        logic [ELAPSED_W-1:0] elapsed;  // ms value the lanes compare against
    } t_lane_ctrl;

endpackage

// ===== design/sync_trigger_clock_generator.sv =====
// ----------------------------------------------------------------------------
// sync_trigger_clock_generator
// multi-channel measurement sync output generator (triggers, edges, clocks)
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | i_in_valid/o_in_stall| i_req_type, i_channel, i_source
//  out     | source    | o_out_valid/i_out_stall | o_levels, o_message,
//          |           |                      | o_message_source
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one beat per cycle sustained while i_out_stall is low; a beat waits in the input register,
//  then its result lands in the output register when the beat advances
//  the output register and the input register form two stages, so a new beat
//  is taken while a finished result waits; stall on the output backs up into
//  o_in_stall only once both stages hold a beat
//  synchronous active-low reset: not running, ms counter zero, all levels
//  high, channel settings at their reset value, source settings zero
//  config writes are always ready and take effect on the edge they land
//
module sync_trigger_clock_generator #(
    parameter int NUM_CHANNELS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // request beats
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [stc_pkg::ID_W-1:0]            i_channel,
    input  logic [stc_pkg::ID_W-1:0]            i_source,

    // result beats
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [NUM_CHANNELS-1:0]             o_levels,
    output logic [2:0]                          o_message,
    output logic [stc_pkg::ID_W-1:0]            o_message_source,

    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [$clog2(NUM_CHANNELS+1)-1:0]   i_cfg_index,
    input  logic [stc_pkg::CHAN_CFG_W-1:0]      i_cfg_data
);

    // input stage
    logic                              r_in_valid;
    logic [1:0]                        r_req_type;
    logic [stc_pkg::ID_W-1:0]          r_channel;
    logic [stc_pkg::ID_W-1:0]          r_source;

    // run state
    logic                              r_running;
    logic                              r_ticks_on;
    logic [stc_pkg::ELAPSED_W-1:0]     r_elapsed;
    logic [stc_pkg::SRC_CFG_W-1:0]     r_src_cfg;

    // output stage
    logic                              r_out_valid;
    logic [NUM_CHANNELS-1:0]           r_levels;
    stc_pkg::t_msg                     r_message;
    logic [stc_pkg::ID_W-1:0]          r_message_source;

    logic                              w_advance;
    logic                              w_in_take;
    logic [stc_pkg::ELAPSED_W-1:0]     w_elapsed_inc;
    logic [stc_pkg::ID_W-1:0]          w_start_src;
    logic [stc_pkg::ID_W-1:0]          w_stop_src;
    logic [stc_pkg::ID_W-1:0]          w_event_src;
    logic                              w_event_en;
    stc_pkg::t_msg                     n_message;
    logic                              n_running;
    logic                              n_ticks_on;
    logic [stc_pkg::ELAPSED_W-1:0]     n_elapsed;
    stc_pkg::t_lane_ctrl               w_ctrl;
    logic [NUM_CHANNELS-1:0]           w_level_next;

    // a beat in the input register moves on whenever the output slot frees
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_req_type <= i_req_type;
            r_channel  <= i_channel;
            r_source   <= i_source;
        end
    end

    // source register fields
    assign w_start_src = r_src_cfg[stc_pkg::SRC_START_LSB +: stc_pkg::ID_W];
    assign w_stop_src  = r_src_cfg[stc_pkg::SRC_STOP_LSB +: stc_pkg::ID_W];
    assign w_event_src = r_src_cfg[stc_pkg::SRC_EVENT_LSB +: stc_pkg::ID_W];
    assign w_event_en  = r_src_cfg[stc_pkg::SRC_EVEN_BIT];

    // ms counter saturates at all ones
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed
                                             : r_elapsed + stc_pkg::ELAPSED_W'(1);

    // source event decode: start/stop sources win over the event source
    always_comb begin
        n_message = stc_pkg::MSG_NONE;
        if (r_req_type == stc_pkg::REQ_EVENT) begin
            if (r_source == w_start_src || r_source == w_stop_src) begin
                if (!r_running) begin
                    if (r_source == w_start_src) begin
                        n_message = stc_pkg::MSG_STARTED;
                    end
                end else if (r_source == w_stop_src) begin
                    n_message = stc_pkg::MSG_STOPPED;
                end
            end else if (w_event_en && r_source == w_event_src) begin
                n_message = stc_pkg::MSG_EVENT;
            end else begin
                n_message = stc_pkg::MSG_UNUSED;
            end
        end
    end

    // next run state
    always_comb begin
        n_running  = r_running;
        n_ticks_on = r_ticks_on;
        n_elapsed  = r_elapsed;
        case (r_req_type)
            stc_pkg::REQ_TICK: begin
                if (r_ticks_on) begin
                    n_elapsed = w_elapsed_inc;
                end
            end
            stc_pkg::REQ_EVENT: begin
                if (n_message == stc_pkg::MSG_STARTED) begin
                    n_running  = 1'b1;
                    n_ticks_on = 1'b1;
                    n_elapsed  = '0;
                end else if (n_message == stc_pkg::MSG_STOPPED) begin
                    n_running = 1'b0;
                    n_elapsed = '0;
                end
            end
            default: begin
                // clock expiries touch only the lanes; code 3 does nothing
            end
        endcase
    end

    // control broadcast to the lanes
    always_comb begin
        w_ctrl.tick     = (r_req_type == stc_pkg::REQ_TICK) && r_ticks_on;
        w_ctrl.running  = r_running;
        w_ctrl.clock    = (r_req_type == stc_pkg::REQ_CLOCK);
        w_ctrl.clock_ch = r_channel;
        w_ctrl.start    = (n_message == stc_pkg::MSG_STARTED);
        w_ctrl.stop     = (n_message == stc_pkg::MSG_STOPPED);
        // ticks compare against the counter after the increment
        w_ctrl.elapsed  = w_ctrl.tick ? w_elapsed_inc : r_elapsed;
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        stc_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cfg_we     (i_cfg_valid && (int'(i_cfg_index) == g)),
            .i_cfg_data   (i_cfg_data),
            .i_advance    (w_advance),
            .i_ctrl       (w_ctrl),
            .o_level_next (w_level_next[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_ticks_on <= 1'b0;
            r_elapsed  <= '0;
        end else if (w_advance) begin
            r_running  <= n_running;
            r_ticks_on <= n_ticks_on;
            r_elapsed  <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cfg <= '0;
        end else if (i_cfg_valid && (int'(i_cfg_index) == NUM_CHANNELS)) begin
            r_src_cfg <= i_cfg_data[stc_pkg::SRC_CFG_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_levels         <= w_level_next;
            r_message        <= n_message;
            r_message_source <= (n_message == stc_pkg::MSG_NONE) ? '0 : r_source;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_levels         = r_levels;
    assign o_message        = r_message;
    assign o_message_source = r_message_source;

`ifndef SYNTHESIS
    a_start_sets_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_message == stc_pkg::MSG_STARTED)
        |=> (r_running && r_ticks_on && r_elapsed == '0))
        else $error("run flag not set after start");

    a_stop_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_message == stc_pkg::MSG_STOPPED)
        |=> (!r_running && r_elapsed == '0))
        else $error("run flag not cleared after stop");

    a_elapsed_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_req_type != stc_pkg::REQ_TICK
         && n_message != stc_pkg::MSG_STARTED && n_message != stc_pkg::MSG_STOPPED)
        |=> $stable(r_elapsed))
        else $error("ms counter moved without a tick");

    a_silent_source_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_message == stc_pkg::MSG_NONE) |-> (r_message_source == '0))
        else $error("source reported without a message");
`endif

endmodule

// ===== design/stc_lane.sv =====
// ----------------------------------------------------------------------------
// stc_lane
// one output channel: settings register, level register, next-level logic
// ----------------------------------------------------------------------------
module stc_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [stc_pkg::CHAN_CFG_W-1:0]  i_cfg_data,
    input  logic                            i_advance,
    input  stc_pkg::t_lane_ctrl             i_ctrl,
    output logic                            o_level_next
);

    logic [stc_pkg::CHAN_CFG_W-1:0] r_cfg;
    logic                           r_level;

    logic                           w_active;
    logic [stc_pkg::MS_W-1:0]       w_delay;
    logic [stc_pkg::FORM_W-1:0]     w_form;
    logic [stc_pkg::MS_W-1:0]       w_pulse;
    logic                           w_stoptrig;
    logic                           w_clk_en;
    logic [stc_pkg::MS_W:0]         w_pulse_end;
    logic                           w_past_delay;
    logic                           w_run_pulse;
    logic                           w_stop_pulse;
    logic                           w_clock_hit;
    logic [stc_pkg::FORM_W-1:0]     w_new_form;
    logic                           n_level;
    logic                           n_cfg_level;

    assign w_active   = r_cfg[stc_pkg::CFG_ACTIVE_BIT];
    assign w_delay    = r_cfg[stc_pkg::CFG_DELAY_LSB +: stc_pkg::MS_W];
    assign w_form     = r_cfg[stc_pkg::CFG_FORM_LSB +: stc_pkg::FORM_W];
    assign w_pulse    = r_cfg[stc_pkg::CFG_PULSE_LSB +: stc_pkg::MS_W];
    assign w_stoptrig = r_cfg[stc_pkg::CFG_STOP_BIT];
    assign w_clk_en   = r_cfg[stc_pkg::CFG_CLK_BIT];

    // pulse window is (delay, delay + pulse]
    assign w_pulse_end  = {1'b0, w_delay} + {1'b0, w_pulse};
    assign w_past_delay = i_ctrl.elapsed >= stc_pkg::ELAPSED_W'(w_delay);
    assign w_run_pulse  = (i_ctrl.elapsed > stc_pkg::ELAPSED_W'(w_delay))
                       && (i_ctrl.elapsed <= stc_pkg::ELAPSED_W'(w_pulse_end));
    assign w_stop_pulse = (i_ctrl.elapsed != '0)
                       && (i_ctrl.elapsed <= stc_pkg::ELAPSED_W'(w_pulse));
    assign w_clock_hit  = i_ctrl.clock && (int'(i_ctrl.clock_ch) == LANE_IDX);

    always_comb begin
        n_level = r_level;
        if (i_ctrl.tick && w_active) begin
            if (i_ctrl.running) begin
                if (w_past_delay && (w_form inside {stc_pkg::FORM_FALL_TRIG,
                                                    stc_pkg::FORM_RISE_TRIG})) begin
                    n_level = w_run_pulse ? w_form[0] : ~w_form[0];
                end
            end else if (w_stoptrig) begin
                n_level = w_stop_pulse ? (w_form != stc_pkg::FORM_FALL_TRIG)
                                       : (w_form == stc_pkg::FORM_FALL_TRIG);
            end
        end
        if (w_clock_hit && i_ctrl.running && w_active && w_clk_en && w_past_delay
            && !(w_form inside {stc_pkg::FORM_FALL_EDGE, stc_pkg::FORM_RISE_EDGE,
                                stc_pkg::FORM_SEQUENCE})) begin
            n_level = ~r_level;
        end
        if (i_ctrl.start && w_active
            && (w_form inside {stc_pkg::FORM_FALL_EDGE, stc_pkg::FORM_RISE_EDGE})) begin
            n_level = ~r_level;
        end
        if (i_ctrl.stop) begin
            case (w_form)
                stc_pkg::FORM_FALL_TRIG,
                stc_pkg::FORM_FALL_EDGE,
                stc_pkg::FORM_FALL_CLK: n_level = 1'b1;
                stc_pkg::FORM_ANY_EDGE: n_level = r_level;
                default:                n_level = 1'b0;
            endcase
        end
    end

    // idle level of the form being written
    assign w_new_form = i_cfg_data[stc_pkg::CFG_FORM_LSB +: stc_pkg::FORM_W];

    always_comb begin
        case (w_new_form)
            stc_pkg::FORM_FALL_TRIG,
            stc_pkg::FORM_FALL_EDGE,
            stc_pkg::FORM_FALL_CLK: n_cfg_level = 1'b1;
            stc_pkg::FORM_ANY_EDGE: n_cfg_level = r_level;
            default:                n_cfg_level = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= stc_pkg::CHAN_CFG_RESET;
            r_level <= 1'b1;
        end else if (i_cfg_we) begin
            r_cfg   <= i_cfg_data;
            r_level <= n_cfg_level;
        end else if (i_advance) begin
            r_level <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule
